### design/qec_pkg.sv
// ----------------------------------------------------------------------------
// qec_pkg: shared types and constants of the quadrature encoder counter
// Command codes, the x4 transition table and the lane result record.
// ----------------------------------------------------------------------------
`default_nettype none

package qec_pkg;

   // default number of encoders handled by the core
   localparam int NUM_ENCODERS_DEF = 2;

   // width of the pin fields of a sample item
   localparam int PIN_WIDTH = 2;

   // field widths
   localparam int CMD_WIDTH     = 2;
   localparam int INDEX_WIDTH   = 2;
   localparam int COUNT_WIDTH   = 16;
   localparam int TIME_WIDTH    = 32;
   localparam int WINDOW_WIDTH  = 16;
   localparam int DETENT_WIDTH  = 14;

   // coarse window after reset
   localparam logic [WINDOW_WIDTH-1:0] WINDOW_RESET = 16'd15;

   // item commands
   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_TICK   = 2'd0,
      CMD_SAMPLE = 2'd1,
      CMD_READ   = 2'd2
   } cmd_type;

   // x4 decoding steps, indexed by {previous pair, new pair}
   typedef logic signed [1:0] step_type;
   localparam step_type STEP_TABLE [16] = '{
      2'sd0, -2'sd1, 2'sd1, 2'sd0, 2'sd1, 2'sd0, 2'sd0, -2'sd1,
      -2'sd1, 2'sd0, 2'sd0, 2'sd1, 2'sd0, 2'sd1, -2'sd1, 2'sd0
   };

   // what one lane shows for a read of its encoder
   typedef struct packed {
      logic signed [DETENT_WIDTH-1:0] detents;
      logic                           coarse_flag;
   } lane_result_type;

endpackage

`default_nettype wire

### design/qec_if.sv
// ----------------------------------------------------------------------------
// qec_if: channel interfaces of the quadrature encoder counter
// Request, response and control register write channels.
// ----------------------------------------------------------------------------
`default_nettype none

// request channel: tick, pin sample or read
interface qec_req_if;
   logic                              valid;
   logic                              ready;
   logic [qec_pkg::CMD_WIDTH-1:0]     cmd;
   logic [qec_pkg::PIN_WIDTH-1:0]     pins_a;
   logic [qec_pkg::PIN_WIDTH-1:0]     pins_b;
   logic [qec_pkg::INDEX_WIDTH-1:0]   encoder_index;

   modport source (output valid, cmd, pins_a, pins_b, encoder_index, input ready);
   modport sink   (input valid, cmd, pins_a, pins_b, encoder_index, output ready);
endinterface

// response channel: read results
interface qec_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [qec_pkg::DETENT_WIDTH-1:0] detents;
   logic                                    coarse_flag;

   modport source (output valid, detents, coarse_flag, input ready);
   modport sink   (input valid, detents, coarse_flag, output ready);
endinterface

// control register write channel: coarse window
interface qec_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [qec_pkg::WINDOW_WIDTH-1:0]      data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

### design/qec_lane.sv
// ----------------------------------------------------------------------------
// qec_lane: one encoder lane
// Keeps pin history, quarter count, detent time and fast-turn flag of one
// encoder; updates on samples, shows count/4 and flag, and on reads keeps the remainder and clears the flag.
// ----------------------------------------------------------------------------
`default_nettype none

module qec_lane (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   sample_en,
   input  wire logic                                   read_en,
   input  wire logic                                   pin_a,
   input  wire logic                                   pin_b,
   input  wire logic [qec_pkg::TIME_WIDTH-1:0]         time_now,
   input  wire logic [qec_pkg::WINDOW_WIDTH-1:0]       coarse_window,
   output qec_pkg::lane_result_type                    result
);

   logic [1:0]                                prev_pins_ff, prev_pins_in;
   logic signed [qec_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   logic [qec_pkg::TIME_WIDTH-1:0]            last_time_ff, last_time_in;
   logic                                      flag_ff, flag_in;

   logic [1:0]                                now_pair;
   qec_pkg::step_type                         step;
   logic signed [qec_pkg::COUNT_WIDTH-1:0]    stepped;
   logic [qec_pkg::TIME_WIDTH-1:0]            elapsed;
   logic signed [qec_pkg::COUNT_WIDTH-1:0]    quot;
   logic signed [qec_pkg::COUNT_WIDTH-1:0]    rem;

   // transition step and detent test
   assign now_pair = {pin_b, pin_a};
   assign step     = qec_pkg::STEP_TABLE[{prev_pins_ff, now_pair}];
   assign stepped  = count_ff + qec_pkg::COUNT_WIDTH'(step);
   assign elapsed  = time_now - last_time_ff;

   // truncating divide by four and remainder with the sign of the count
   assign quot = count_ff[qec_pkg::COUNT_WIDTH-1] ? ((count_ff + 16'sd3) >>> 2)
                                                 : (count_ff >>> 2);
   assign rem  = count_ff - (quot <<< 2);

   assign result = '{detents: quot[qec_pkg::DETENT_WIDTH-1:0], coarse_flag: flag_ff};

   // next state
   always_comb begin
      prev_pins_in = prev_pins_ff;
      count_in     = count_ff;
      last_time_in = last_time_ff;
      flag_in      = flag_ff;
      if (sample_en) begin
         prev_pins_in = now_pair;
         if (step != 2'sd0) begin
            count_in = stepped;
            if ((stepped >= 16'sd4) || (stepped <= -16'sd4)) begin
               if (elapsed < qec_pkg::TIME_WIDTH'(coarse_window)) begin
                  flag_in = 1'b1;
               end
               last_time_in = time_now;
            end
         end
      end else if (read_en) begin
         count_in = rem;
         flag_in  = 1'b0;
      end
   end

   // lane state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_pins_ff <= '0;
         count_ff     <= '0;
         last_time_ff <= '0;
         flag_ff      <= 1'b0;
      end else begin
         prev_pins_ff <= prev_pins_in;
         count_ff     <= count_in;
         last_time_ff <= last_time_in;
         flag_ff      <= flag_in;
      end
   end

   // a read leaves less than one detent in the count
   assert property (@(posedge clock) disable iff (reset)
      read_en && !sample_en |=> (count_ff < 16'sd4) && (count_ff > -16'sd4))
      else $error("lane count not reduced below one detent after read");

   // a read clears the flag
   assert property (@(posedge clock) disable iff (reset)
      read_en && !sample_en |=> !flag_ff)
      else $error("lane flag not cleared after read");

   // a detent stamps the present time
   assert property (@(posedge clock) disable iff (reset)
      sample_en && (step != 2'sd0) && ((stepped >= 16'sd4) || (stepped <= -16'sd4))
      |=> last_time_ff == $past(time_now))
      else $error("detent time not updated");

endmodule

`default_nettype wire

### design/qec_merge.sv
// ----------------------------------------------------------------------------
// qec_merge: lane selection and response register
// Picks the addressed lane's read result, zero for an index with no lane,
// and holds it in the output register until the response is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module qec_merge #(
   parameter int NumEncoders = qec_pkg::NUM_ENCODERS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 load,
   input  wire logic [qec_pkg::INDEX_WIDTH-1:0]      encoder_index,
   input  qec_pkg::lane_result_type                  lane_results [NumEncoders],
   output logic                                      free,
   qec_rsp_if.source                                 rsp_bus
);

   logic                        valid_ff, valid_in;
   qec_pkg::lane_result_type    data_ff, data_in, selected;

   // select the addressed lane; no match gives zero
   always_comb begin
      selected = '0;
      for (int i = 0; i < NumEncoders; i++) begin
         if (int'(encoder_index) == i) begin
            selected = lane_results[i];
         end
      end
   end

   assign free = !valid_ff || rsp_bus.ready;

   // output register control
   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (free) begin
         valid_in = load;
         if (load) begin
            data_in = selected;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.detents     = data_ff.detents;
   assign rsp_bus.coarse_flag = data_ff.coarse_flag;

   // every load is shown as a response next cycle
   assert property (@(posedge clock) disable iff (reset)
      load && free |=> valid_ff)
      else $error("loaded item not presented");

   // a response appears only after a load
   assert property (@(posedge clock) disable iff (reset)
      $rose(valid_ff) |-> $past(load))
      else $error("response without a read");

   // an index with no lane reads as zero
   assert property (@(posedge clock) disable iff (reset)
      load && free && (int'(encoder_index) >= NumEncoders) |=> data_ff == '0)
      else $error("invalid index gave nonzero response");

endmodule

`default_nettype wire

### design/quadrature_encoder_counter_core.sv
// ----------------------------------------------------------------------------
// quadrature_encoder_counter_core: x4 decoder for several quadrature encoders
// One lane per encoder updates on pin samples; a merge stage returns the
// addressed lane's detent count and fast-turn flag for read items.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle while ready is high; on a sample every lane updates in the cycle of accept.
// A read result is in the response register in the cycle after accept.
// Ready drops only while a response is held and not taken.
// Reset: counts, pin history, detent times, flags and time clear; window is 15.
`default_nettype none

module quadrature_encoder_counter_core #(
   parameter int NUM_ENCODERS = qec_pkg::NUM_ENCODERS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   qec_req_if.sink      req_bus,
   qec_rsp_if.source    rsp_bus,
   qec_csr_if.sink      csr_bus
);

   logic [qec_pkg::WINDOW_WIDTH-1:0]   window_ff, window_in;
   logic [qec_pkg::TIME_WIDTH-1:0]     time_now_ff, time_now_in;

   logic                               free;
   logic                               accept;
   logic                               is_tick;
   logic                               is_sample;
   logic                               is_read;
   logic [NUM_ENCODERS-1:0]            lane_a;
   logic [NUM_ENCODERS-1:0]            lane_b;
   logic [NUM_ENCODERS-1:0]            lane_read;
   qec_pkg::lane_result_type           lane_results [NUM_ENCODERS];

   // request decode
   assign req_bus.ready = free;
   assign accept    = req_bus.valid && free;
   assign is_tick   = accept && (req_bus.cmd == qec_pkg::CMD_TICK);
   assign is_sample = accept && (req_bus.cmd == qec_pkg::CMD_SAMPLE);
   assign is_read   = accept && (req_bus.cmd == qec_pkg::CMD_READ);

   // control register and tick-driven time
   assign csr_bus.ready = 1'b1;
   assign window_in   = csr_bus.valid ? csr_bus.data : window_ff;
   assign time_now_in = is_tick ? time_now_ff + 32'd1 : time_now_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff   <= qec_pkg::WINDOW_RESET;
         time_now_ff <= '0;
      end else begin
         window_ff   <= window_in;
         time_now_ff <= time_now_in;
      end
   end

   // encoder lanes
   for (genvar i = 0; i < NUM_ENCODERS; i++) begin : g_lane
      if (i < qec_pkg::PIN_WIDTH) begin : g_pin
         assign lane_a[i] = req_bus.pins_a[i];
         assign lane_b[i] = req_bus.pins_b[i];
      end else begin : g_nopin
         assign lane_a[i] = 1'b0;
         assign lane_b[i] = 1'b0;
      end

      assign lane_read[i] = is_read && (int'(req_bus.encoder_index) == i);

      qec_lane u_lane (
         .clock         (clock),
         .reset         (reset),
         .sample_en     (is_sample),
         .read_en       (lane_read[i]),
         .pin_a         (lane_a[i]),
         .pin_b         (lane_b[i]),
         .time_now      (time_now_ff),
         .coarse_window (window_ff),
         .result        (lane_results[i])
      );
   end

   // lane merge and response register
   qec_merge #(
      .NumEncoders (NUM_ENCODERS)
   ) u_merge (
      .clock         (clock),
      .reset         (reset),
      .load          (is_read),
      .encoder_index (req_bus.encoder_index),
      .lane_results  (lane_results),
      .free          (free),
      .rsp_bus       (rsp_bus)
   );

   // time advances by one on each tick item only
   assert property (@(posedge clock) disable iff (reset)
      is_tick |=> time_now_ff == $past(time_now_ff) + 32'd1)
      else $error("time not advanced on tick");

   assert property (@(posedge clock) disable iff (reset)
      accept && !is_tick |=> $stable(time_now_ff))
      else $error("time changed without tick");

   // at most one lane is read per item
   assert property (@(posedge clock) disable iff (reset)
      $onehot0(lane_read))
      else $error("more than one lane read");

endmodule

`default_nettype wire

### test/tb_quadrature_encoder_counter_core.sv
// ----------------------------------------------------------------------------
// tb_quadrature_encoder_counter_core: self-checking bench of the x4 decoder
// Drives ticks, pin samples and reads through the request channel, keeps a
// shadow of counts, detent times and fast-turn flags, and checks every read
// result in order. Both channels idle at random; the coarse window is
// rewritten between phases while the core is quiet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_quadrature_encoder_counter_core;

   localparam int ENCODERS = qec_pkg::NUM_ENCODERS_DEF;

   // command code with no function
   localparam logic [qec_pkg::CMD_WIDTH-1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset;

   qec_req_if req_bus ();
   qec_rsp_if rsp_bus ();
   qec_csr_if csr_bus ();

   quadrature_encoder_counter_core #(
      .NUM_ENCODERS(ENCODERS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   always #1 clock = ~clock;

   // shadow of the decoder state
   logic [1:0]                               last_pair    [ENCODERS];
   logic signed [qec_pkg::COUNT_WIDTH-1:0]   quarters     [ENCODERS];
   logic [qec_pkg::TIME_WIDTH-1:0]           detent_stamp [ENCODERS];
   logic                                     fast_seen    [ENCODERS];
   logic [qec_pkg::TIME_WIDTH-1:0]           tick_count;
   logic [qec_pkg::WINDOW_WIDTH-1:0]         window;

   // read results still to come, oldest first
   qec_pkg::lane_result_type pending_reads [$];

   int  mismatches = 0;
   bit  steady     = 1'b0;
   bit  turning_up [ENCODERS];

   // random idle cycle, about 15 in 100 unless in a steady stretch
   function automatic bit take_break();
      return !steady && ($urandom_range(99) < 15);
   endfunction

   // quarter step for a {previous pair, new pair} code
   function automatic int quarter_step(input logic [3:0] code);
      int step;
      case (code)
         4'd2, 4'd4, 4'd11, 4'd13: step = 1;
         4'd1, 4'd7, 4'd8, 4'd14:  step = -1;
         default:                  step = 0;
      endcase
      return step;
   endfunction

   // next pin pair one quarter step up or down
   function automatic logic [1:0] next_pair(input logic [1:0] pair, input bit up);
      logic [1:0] nxt;
      if (up) begin
         case (pair)
            2'd0:    nxt = 2'd2;
            2'd2:    nxt = 2'd3;
            2'd3:    nxt = 2'd1;
            default: nxt = 2'd0;
         endcase
      end else begin
         case (pair)
            2'd0:    nxt = 2'd1;
            2'd1:    nxt = 2'd3;
            2'd3:    nxt = 2'd2;
            default: nxt = 2'd0;
         endcase
      end
      return nxt;
   endfunction

   // update the shadow state for one accepted item, queue any read result
   task automatic decode_item(input logic [1:0] cmd, input logic [1:0] pa,
                              input logic [1:0] pb, input logic [1:0] idx);
      qec_pkg::lane_result_type res;
      logic [1:0]      now_pair;
      logic [31:0]     elapsed;
      int              step;
      int              c;
      int              q;
      int              r;
      case (cmd)
         qec_pkg::CMD_TICK: tick_count = tick_count + 32'd1;
         qec_pkg::CMD_SAMPLE: begin
            for (int i = 0; i < ENCODERS; i++) begin
               now_pair = {pb[i], pa[i]};
               step = quarter_step({last_pair[i], now_pair});
               last_pair[i] = now_pair;
               if (step != 0) begin
                  quarters[i] = 16'(quarters[i] + step);
                  c = quarters[i];
                  if (c / 4 != 0) begin
                     elapsed = tick_count - detent_stamp[i];
                     if (elapsed < {16'd0, window}) fast_seen[i] = 1'b1;
                     detent_stamp[i] = tick_count;
                  end
               end
            end
         end
         qec_pkg::CMD_READ: begin
            res = '0;
            if (idx < ENCODERS) begin
               c = quarters[idx];
               q = c / 4;
               r = c % 4;
               res.detents     = q[qec_pkg::DETENT_WIDTH-1:0];
               res.coarse_flag = fast_seen[idx];
               quarters[idx]   = r[qec_pkg::COUNT_WIDTH-1:0];
               fast_seen[idx]  = 1'b0;
            end
            pending_reads.push_back(res);
         end
         default: ;
      endcase
   endtask

   // present one item, wait for accept, then update the shadow
   task automatic send_item(input logic [1:0] cmd, input logic [1:0] pa,
                            input logic [1:0] pb, input logic [1:0] idx);
      while (take_break()) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= cmd;
      req_bus.pins_a        <= pa;
      req_bus.pins_b        <= pb;
      req_bus.encoder_index <= idx;
      do @(posedge clock); while (!req_bus.ready);
      decode_item(cmd, pa, pb, idx);
   endtask

   // pin sample from one pair per encoder
   task automatic send_pairs(input logic [1:0] p0, input logic [1:0] p1);
      send_item(qec_pkg::CMD_SAMPLE, {p1[0], p0[0]}, {p1[1], p0[1]},
                2'($urandom_range(3)));
   endtask

   task automatic send_read(input logic [1:0] idx);
      send_item(qec_pkg::CMD_READ, 2'($urandom_range(3)), 2'($urandom_range(3)), idx);
   endtask

   task automatic send_tick();
      send_item(qec_pkg::CMD_TICK, 2'($urandom_range(3)), 2'($urandom_range(3)),
                2'($urandom_range(3)));
   endtask

   // hold off the sender until every read result is back
   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (pending_reads.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [qec_pkg::WINDOW_WIDTH-1:0] value);
      csr_bus.data  <= value;
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      window = value;
      csr_bus.valid <= 1'b0;
   endtask

   // reads at reset, every pin transition, invalid indexes, unused command
   task automatic test_transitions();
      logic [1:0] walk [17] = '{2'd0, 2'd0, 2'd1, 2'd0, 2'd2, 2'd0, 2'd3, 2'd1,
                                2'd1, 2'd2, 2'd1, 2'd3, 2'd2, 2'd2, 2'd3, 2'd3, 2'd0};
      send_read(2'd0);
      send_read(2'd1);
      foreach (walk[k]) send_pairs(walk[k], walk[k] ^ 2'd1);
      send_read(2'd0);
      send_read(2'd1);
      send_read(2'd2);
      send_read(2'd3);
      send_tick();
      send_item(CMD_UNUSED, 2'd3, 2'd3, 2'd0);
      send_read(2'd0);
   endtask

   // quick detents set the flag; a read, a pause of ticks and more detents follow
   task automatic test_fast_turn();
      logic [1:0] p0;
      logic [1:0] p1;
      settle_block();
      p0 = last_pair[0];
      p1 = last_pair[1];
      repeat (6) begin
         p0 = next_pair(p0, 1'b1);
         p1 = next_pair(p1, 1'b0);
         send_pairs(p0, p1);
      end
      send_read(2'd0);
      send_read(2'd1);
      repeat (16) send_tick();
      repeat (4) begin
         p0 = next_pair(p0, 1'b1);
         p1 = next_pair(p1, 1'b0);
         send_pairs(p0, p1);
      end
      send_read(2'd0);
      send_read(2'd1);
   endtask

   // counts run many detents up and down from zero
   task automatic test_long_run();
      logic [1:0] p0;
      logic [1:0] p1;
      settle_block();
      p0 = last_pair[0];
      p1 = last_pair[1];
      // bring both counts to zero first
      while (quarters[0] != 0 || quarters[1] != 0) begin
         if (quarters[0] != 0) p0 = next_pair(p0, quarters[0] < 0);
         if (quarters[1] != 0) p1 = next_pair(p1, quarters[1] < 0);
         send_pairs(p0, p1);
      end
      // encoder 0 up, encoder 1 down
      repeat (161) begin
         p0 = next_pair(p0, 1'b1);
         p1 = next_pair(p1, 1'b0);
         send_pairs(p0, p1);
      end
      send_read(2'd0);
      // encoder 1 one more step down
      p1 = next_pair(p1, 1'b0);
      send_pairs(p0, p1);
      send_read(2'd1);
      send_read(2'd0);
   endtask

   // mostly clean rotation with random direction changes, ticks, reads, noise and unused commands
   task automatic test_random_phase(input logic [qec_pkg::WINDOW_WIDTH-1:0] value,
                                    input int tick_pct, input int count);
      int         sent;
      int         roll;
      logic [1:0] p0;
      logic [1:0] p1;
      settle_block();
      write_window(value);
      sent = 0;
      while (sent < count) begin
         roll = $urandom_range(99);
         if (roll < tick_pct) begin
            send_tick();
            sent++;
         end else if (roll < tick_pct + 10) begin
            send_read(($urandom_range(99) < 85) ? 2'($urandom_range(ENCODERS - 1))
                                                : 2'($urandom_range(3)));
            sent++;
         end else if (roll < tick_pct + 13) begin
            send_item(CMD_UNUSED, 2'($urandom_range(3)), 2'($urandom_range(3)),
                      2'($urandom_range(3)));
         end else if (roll < tick_pct + 18) begin
            // noise: any pin levels, double jumps included
            send_pairs(2'($urandom_range(3)), 2'($urandom_range(3)));
            sent++;
         end else begin
            for (int i = 0; i < ENCODERS; i++)
               if ($urandom_range(99) < 5) turning_up[i] = !turning_up[i];
            p0 = last_pair[0];
            p1 = last_pair[1];
            if ($urandom_range(99) >= 20) p0 = next_pair(p0, turning_up[0]);
            if ($urandom_range(99) >= 20) p1 = next_pair(p1, turning_up[1]);
            send_pairs(p0, p1);
            sent++;
         end
      end
   endtask

   // check each read result against the oldest expectation
   always @(posedge clock) begin : check_reads
      qec_pkg::lane_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_reads.size() == 0) begin
            $error("read result with none expected: detents %0d, coarse_flag %0b",
                   rsp_bus.detents, rsp_bus.coarse_flag);
            mismatches++;
         end else begin
            want = pending_reads.pop_front();
            if (rsp_bus.detents !== want.detents) begin
               $error("detents: expected %0d, got %0d", want.detents, rsp_bus.detents);
               mismatches++;
            end
            if (rsp_bus.coarse_flag !== want.coarse_flag) begin
               $error("coarse_flag: expected %0b, got %0b", want.coarse_flag,
                      rsp_bus.coarse_flag);
               mismatches++;
            end
         end
      end
      rsp_bus.ready <= !take_break();
   end

   // run limit
   initial begin
      #2_000_000;
      $display("quadrature_encoder_counter_core verification failed");
      $finish;
   end

   initial begin
      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cmd           = qec_pkg::CMD_TICK;
      req_bus.pins_a        = '0;
      req_bus.pins_b        = '0;
      req_bus.encoder_index = '0;
      rsp_bus.ready         = 1'b0;
      csr_bus.valid         = 1'b0;
      csr_bus.data          = '0;
      for (int i = 0; i < ENCODERS; i++) begin
         last_pair[i]    = '0;
         quarters[i]     = '0;
         detent_stamp[i] = '0;
         fast_seen[i]    = 1'b0;
         turning_up[i]   = 1'(i);
      end
      tick_count = '0;
      window     = qec_pkg::WINDOW_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_transitions();
      test_fast_turn();
      test_long_run();
      test_random_phase(16'd0, 30, 125);
      steady = 1'b1;
      test_random_phase(16'hFFFF, 30, 125);
      steady = 1'b0;
      test_random_phase(16'd3, 45, 125);
      test_random_phase(qec_pkg::WINDOW_RESET, 25, 125);
      test_random_phase(16'($urandom_range(1, 40)), 35, 125);

      settle_block();
      if (mismatches == 0)
         $display("quadrature_encoder_counter_core verification clean");
      else
         $display("quadrature_encoder_counter_core verification failed");
      $finish;
   end

endmodule
